[hdl/wsfr_pkg.sv]
// Package with the phase codes, header constants and result type of the frame receiver.
package wsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned MaskN  = 4;
  localparam int unsigned MaskIdxW = $clog2(MaskN);

  localparam logic [ByteW-1:0] LenFieldMask = 8'h7f;
  localparam logic [6:0]       LenExtended  = 7'd126;
  localparam logic [6:0]       LenFail      = 7'd127;

  localparam logic [PhaseW-1:0] PhHdr0    = 4'd0;
  localparam logic [PhaseW-1:0] PhHdr1    = 4'd1;
  localparam logic [PhaseW-1:0] PhExtHi   = 4'd2;
  localparam logic [PhaseW-1:0] PhExtLo   = 4'd3;
  localparam logic [PhaseW-1:0] PhMask0   = 4'd4;
  localparam logic [PhaseW-1:0] PhMask1   = 4'd5;
  localparam logic [PhaseW-1:0] PhMask2   = 4'd6;
  localparam logic [PhaseW-1:0] PhMask3   = 4'd7;
  localparam logic [PhaseW-1:0] PhPayload = 4'd8;
  localparam logic [PhaseW-1:0] PhClosed  = 4'd9;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_end;
    logic             length_error;
  } result_t;

endpackage

[hdl/wsfr_in_reg.sv]
// Input register that holds one received byte until the deframer consumes it.
module wsfr_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wsfr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         take_i,
  output logic                         byte_valid_o,
  output logic [wsfr_pkg::ByteW-1:0]   byte_o
);

  logic                       valid_q, valid_d;
  logic [wsfr_pkg::ByteW-1:0] byte_q;
  logic                       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

[hdl/wsfr_parser.sv]
// Frame state, mask store and per-byte unmasking logic of the frame receiver.
module wsfr_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [wsfr_pkg::ByteW-1:0]   byte_i,
  output logic                         res_valid_o,
  output wsfr_pkg::result_t            res_o
);

  logic [wsfr_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [wsfr_pkg::LenW-1:0]     len_q, len_d;
  logic [wsfr_pkg::MaskIdxW-1:0] idx_q, idx_d;
  logic [wsfr_pkg::ByteW-1:0]    mask_q [wsfr_pkg::MaskN];
  logic                          mask_we;
  logic [6:0]                    code;
  logic [wsfr_pkg::LenW-1:0]     len_dec;

  assign code    = 7'(byte_i & wsfr_pkg::LenFieldMask);
  assign len_dec = len_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    idx_d       = idx_q;
    mask_we     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      wsfr_pkg::PhHdr1: begin
        if (code == wsfr_pkg::LenFail) begin
          len_d              = '0;
          idx_d              = '0;
          phase_d            = wsfr_pkg::PhClosed;
          res_valid_o        = 1'b1;
          res_o.length_error = 1'b1;
        end else if (code == wsfr_pkg::LenExtended) begin
          phase_d = wsfr_pkg::PhExtHi;
        end else begin
          len_d   = wsfr_pkg::LenW'(code);
          phase_d = wsfr_pkg::PhMask0;
        end
      end
      wsfr_pkg::PhExtHi: begin
        len_d   = {byte_i, 8'h00};
        phase_d = wsfr_pkg::PhExtLo;
      end
      wsfr_pkg::PhExtLo: begin
        len_d   = {len_q[15:8], byte_i};
        phase_d = wsfr_pkg::PhMask0;
      end
      wsfr_pkg::PhMask0, wsfr_pkg::PhMask1, wsfr_pkg::PhMask2: begin
        mask_we = 1'b1;
        phase_d = phase_q + 4'd1;
      end
      wsfr_pkg::PhMask3: begin
        mask_we = 1'b1;
        idx_d   = '0;
        phase_d = (len_q == '0) ? wsfr_pkg::PhHdr0 : wsfr_pkg::PhPayload;
      end
      wsfr_pkg::PhPayload: begin
        idx_d              = idx_q + 2'd1;
        len_d              = len_dec;
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i ^ mask_q[idx_q];
        res_o.frame_end    = (len_dec == '0);
        if (len_dec == '0) begin
          phase_d = wsfr_pkg::PhHdr0;
        end
      end
      wsfr_pkg::PhClosed: begin
        phase_d = wsfr_pkg::PhClosed;
      end
      default: begin
        phase_d = wsfr_pkg::PhHdr1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsfr_pkg::PhHdr0;
      len_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < wsfr_pkg::MaskN; i++) begin
        mask_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      if (mask_we) begin
        mask_q[phase_q[wsfr_pkg::MaskIdxW-1:0]] <= byte_i;
      end
    end
  end

endmodule

[hdl/wsfr_out_reg.sv]
// Result register that holds one deframed byte until the receiver takes it.
module wsfr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              res_valid_i,
  input  wsfr_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsfr_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  wsfr_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hdl/websocket_frame_receiver.sv]
// Top level of the WebSocket frame receiver.
// The input channel (in_valid_i, in_ready_o, rx_byte_i) takes one raw link byte
// per request. The output channel (out_valid_o, out_ready_i) gives one request per
// payload byte: payload_byte_o is the unmasked byte and frame_end_o marks the last
// byte of a frame. A length code of 127 gives one request with length_error_o set
// and zero payload, after which every byte is accepted and dropped until reset.
// Header, extended length and mask bytes, and zero-length frames, give no request.
// A byte held in the input register is processed once the output side is free, and
// processing loads its result into the result register, which holds the request
// until the receiver takes it.
// One byte is accepted per cycle
// while the output side takes results; the rate is set by the single state update
// between the two registers.
// Reset clears both registers and returns the deframer to waiting for a header.
// When the receiver stalls, the result register holds its request and the input
// register still takes one byte; in_ready_o then drops until the output frees.
module websocket_frame_receiver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wsfr_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wsfr_pkg::ByteW-1:0] payload_byte_o,
  output logic                       frame_end_o,
  output logic                       length_error_o
);

  logic                       byte_valid;
  logic [wsfr_pkg::ByteW-1:0] byte_q;
  logic                       out_free;
  logic                       step;
  logic                       res_valid;
  wsfr_pkg::result_t          res;
  wsfr_pkg::result_t          out_res;

  assign step = byte_valid && out_free;

  wsfr_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .take_i      (step),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_q)
  );

  wsfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  wsfr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .res_valid_i(res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign frame_end_o    = out_res.frame_end;
  assign length_error_o = out_res.length_error;

endmodule

[hdl/wsfr_checker.sv]
// Port-level checker for the frame receiver, bound to the top level.
module wsfr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [wsfr_pkg::ByteW-1:0] payload_byte_o,
  input logic                       frame_end_o,
  input logic                       length_error_o
);

  logic closed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && length_error_o) begin
      closed_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(frame_end_o) && $stable(length_error_o))
    else $error("Stalled result request changed.");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> payload_byte_o == '0 && !frame_end_o)
    else $error("Length error request carries payload.");

  a_closed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |-> !out_valid_o)
    else $error("Result request after the link was closed.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while no result is pending.");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .payload_byte_o(payload_byte_o),
  .frame_end_o   (frame_end_o),
  .length_error_o(length_error_o)
);

[bench/tb_websocket_frame_receiver.sv]
// Self-checking testbench for the WebSocket frame receiver, with a frame scoreboard.
`timescale 1ns / 100ps

module tb_websocket_frame_receiver;

  class frame_scoreboard;
    logic [wsfr_pkg::PhaseW-1:0]   phase;
    logic [wsfr_pkg::LenW-1:0]     bytes_left;
    logic [wsfr_pkg::ByteW-1:0]    key_bytes [wsfr_pkg::MaskN];
    logic [wsfr_pkg::MaskIdxW-1:0] key_idx;
    wsfr_pkg::result_t             expected_bytes [$];
    int unsigned                   mismatches;

    function new();
      phase = wsfr_pkg::PhHdr0;
      bytes_left = '0;
      foreach (key_bytes[k]) key_bytes[k] = '0;
      key_idx = '0;
      mismatches = 0;
    endfunction

    function void deframe_byte(logic [wsfr_pkg::ByteW-1:0] b);
      wsfr_pkg::result_t          r;
      logic [wsfr_pkg::ByteW-1:0] code;
      code = b & wsfr_pkg::LenFieldMask;
      case (phase)
        wsfr_pkg::PhHdr1: begin
          if (code[6:0] == wsfr_pkg::LenFail) begin
            bytes_left = '0;
            key_idx = '0;
            phase = wsfr_pkg::PhClosed;
            r.payload_byte = '0;
            r.frame_end = 1'b0;
            r.length_error = 1'b1;
            expected_bytes.push_back(r);
          end else if (code[6:0] == wsfr_pkg::LenExtended) begin
            phase = wsfr_pkg::PhExtHi;
          end else begin
            bytes_left = {8'h00, code};
            phase = wsfr_pkg::PhMask0;
          end
        end
        wsfr_pkg::PhExtHi: begin
          bytes_left = {b, 8'h00};
          phase = wsfr_pkg::PhExtLo;
        end
        wsfr_pkg::PhExtLo: begin
          bytes_left = bytes_left | {8'h00, b};
          phase = wsfr_pkg::PhMask0;
        end
        wsfr_pkg::PhMask0, wsfr_pkg::PhMask1, wsfr_pkg::PhMask2, wsfr_pkg::PhMask3: begin
          key_bytes[phase - wsfr_pkg::PhMask0] = b;
          if (phase == wsfr_pkg::PhMask3) begin
            key_idx = '0;
            phase = (bytes_left == 0) ? wsfr_pkg::PhHdr0 : wsfr_pkg::PhPayload;
          end else begin
            phase = phase + 1'b1;
          end
        end
        wsfr_pkg::PhPayload: begin
          bytes_left = bytes_left - 1'b1;
          r.payload_byte = b ^ key_bytes[key_idx];
          r.frame_end = (bytes_left == 0);
          r.length_error = 1'b0;
          expected_bytes.push_back(r);
          key_idx = key_idx + 1'b1;
          if (bytes_left == 0) phase = wsfr_pkg::PhHdr0;
        end
        wsfr_pkg::PhClosed: begin
        end
        default: begin
          phase = wsfr_pkg::PhHdr1;
        end
      endcase
    endfunction

    function void check_result(logic [wsfr_pkg::ByteW-1:0] data, logic last, logic err);
      wsfr_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, got payload %02h end %b error %b",
                 $time, data, last, err);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.payload_byte) begin
        $display("%0t: payload_byte expected %02h, got %02h", $time, want.payload_byte, data);
        mismatches++;
      end
      if (last !== want.frame_end) begin
        $display("%0t: frame_end expected %b, got %b", $time, want.frame_end, last);
        mismatches++;
      end
      if (err !== want.length_error) begin
        $display("%0t: length_error expected %b, got %b", $time, want.length_error, err);
        mismatches++;
      end
    endfunction
  endclass

  localparam logic [wsfr_pkg::ByteW-1:0] OpeningBytes [25] = '{
    8'h81, 8'h85, 8'h00, 8'hff, 8'ha5, 8'h5a, 8'h00, 8'hff, 8'h5a, 8'ha5, 8'h3c,
    8'h00, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
    8'hff, 8'h7e, 8'h00, 8'h00, 8'hde, 8'had, 8'hbe, 8'hef
  };

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic [wsfr_pkg::ByteW-1:0] rx_byte = '0;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic [wsfr_pkg::ByteW-1:0] payload_byte;
  logic                       frame_end;
  logic                       length_error;

  frame_scoreboard            sb = new();
  int unsigned                n_taken = 0;
  int unsigned                n_offered = 0;
  int unsigned                burst_left = 0;
  bit                         long_hold = 1'b0;
  logic [wsfr_pkg::ByteW-1:0] frame_q [$];

  websocket_frame_receiver DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .payload_byte_o (payload_byte),
    .frame_end_o    (frame_end),
    .length_error_o (length_error)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.deframe_byte(rx_byte);
        n_taken <= n_taken + 1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(payload_byte, frame_end, length_error);
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (long_hold) begin
          out_ready <= 1'b0;
          repeat (300) @(negedge clk_i);
          long_hold = 1'b0;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [wsfr_pkg::ByteW-1:0] noise_byte();
    return {1'($urandom), 1'b0, 6'($urandom)};
  endfunction

  function automatic void build_frame(int unsigned len, bit ext);
    logic [wsfr_pkg::LenW-1:0] ext_len;
    ext_len = wsfr_pkg::LenW'(len);
    frame_q.delete();
    frame_q.push_back(8'($urandom));
    if (ext || len > 125) begin
      frame_q.push_back({1'($urandom), wsfr_pkg::LenExtended});
      frame_q.push_back(ext_len[15:8]);
      frame_q.push_back(ext_len[7:0]);
    end else begin
      frame_q.push_back({1'($urandom), 7'(len)});
    end
    for (int k = 0; k < wsfr_pkg::MaskN; k++) frame_q.push_back(8'($urandom));
    for (int k = 0; k < len; k++) frame_q.push_back(8'($urandom));
  endfunction

  task automatic offer_byte(input logic [wsfr_pkg::ByteW-1:0] b);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    seen = n_taken;
    n_offered++;
    do @(negedge clk_i); while (n_taken == seen);
  endtask

  task automatic offer_frame();
    foreach (frame_q[k]) offer_byte(frame_q[k]);
  endtask

  task automatic send_frame(input int unsigned len, input bit ext);
    build_frame(len, ext);
    offer_frame();
  endtask

  task automatic realign();
    while (sb.phase != wsfr_pkg::PhHdr0) offer_byte(noise_byte());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (sb.expected_bytes.size() != 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned cut;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    foreach (OpeningBytes[k]) offer_byte(OpeningBytes[k]);

    long_hold = 1'b1;
    send_frame(300, 1'b1);
    drain();
    send_frame(125, 1'b0);
    send_frame(1, 1'b1);

    while (n_offered < 1050) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_frame($urandom_range(1, 16), 1'b0);
      end else if (pick < 58) begin
        send_frame(0, 1'($urandom));
      end else if (pick < 70) begin
        send_frame($urandom_range(0, 40), 1'b1);
      end else if (pick < 77) begin
        send_frame($urandom_range(17, 125), 1'b0);
      end else if (pick < 78) begin
        send_frame($urandom_range(126, 400), 1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) offer_byte(noise_byte());
        realign();
      end else begin
        build_frame($urandom_range(0, 24), 1'($urandom));
        cut = $urandom_range(1, frame_q.size() - 1);
        repeat (cut) void'(frame_q.pop_back());
        offer_frame();
        realign();
      end
      if ($urandom_range(0, 29) == 0) drain();
    end

    // A length code of 127 closes the link for good, so it comes last.
    offer_byte(8'($urandom));
    offer_byte(8'hff);
    repeat (16) offer_byte(8'($urandom));

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/wsfr_pkg.sv
hdl/wsfr_in_reg.sv
hdl/wsfr_parser.sv
hdl/wsfr_out_reg.sv
hdl/websocket_frame_receiver.sv
hdl/wsfr_checker.sv
bench/tb_websocket_frame_receiver.sv
